// ----- hw/rtl/afk_pkg.sv -----
// afk_pkg: shared constants, types and CORDIC arctangent table for the
// 3-DOF forward kinematics core. No dependencies.
`timescale 1ns / 1ps
package afk_pkg;

  localparam int CordicSteps = 30;
  localparam int CordicScale = 30;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

  typedef enum logic [0:0] {
    CFG_L2 = 1'b0,
    CFG_L3 = 1'b1
  } cfg_idx_t;

  function automatic logic signed [CordicW-1:0] arc_step(input logic [4:0] i);
    case (i)
      5'd0:  arc_step = 34'sd536870912;
      5'd1:  arc_step = 34'sd316933406;
      5'd2:  arc_step = 34'sd167458907;
      5'd3:  arc_step = 34'sd85004756;
      5'd4:  arc_step = 34'sd42667331;
      5'd5:  arc_step = 34'sd21354465;
      5'd6:  arc_step = 34'sd10679838;
      5'd7:  arc_step = 34'sd5340245;
      5'd8:  arc_step = 34'sd2670163;
      5'd9:  arc_step = 34'sd1335087;
      5'd10: arc_step = 34'sd667544;
      5'd11: arc_step = 34'sd333772;
      5'd12: arc_step = 34'sd166886;
      5'd13: arc_step = 34'sd83443;
      5'd14: arc_step = 34'sd41722;
      5'd15: arc_step = 34'sd20861;
      5'd16: arc_step = 34'sd10430;
      5'd17: arc_step = 34'sd5215;
      5'd18: arc_step = 34'sd2608;
      5'd19: arc_step = 34'sd1304;
      5'd20: arc_step = 34'sd652;
      5'd21: arc_step = 34'sd326;
      5'd22: arc_step = 34'sd163;
      5'd23: arc_step = 34'sd81;
      5'd24: arc_step = 34'sd41;
      5'd25: arc_step = 34'sd20;
      5'd26: arc_step = 34'sd10;
      5'd27: arc_step = 34'sd5;
      5'd28: arc_step = 34'sd3;
      5'd29: arc_step = 34'sd1;
      default: arc_step = '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/afk_cordic_lane.sv -----
// afk_cordic_lane: pipelined rotation-mode CORDIC, one step per stage,
// sine and cosine of a binary angle. Uses afk_pkg.
`timescale 1ns / 1ps
module afk_cordic_lane #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                          clk,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  output logic signed [FRACTION_BITS+1:0] sin_q,
  output logic signed [FRACTION_BITS+1:0] cos_q
);
  localparam int W  = afk_pkg::CordicW;
  localparam int N  = afk_pkg::CordicSteps;
  localparam int RS = afk_pkg::CordicScale - FRACTION_BITS;
  localparam int OW = FRACTION_BITS + 2;

  logic signed [W-1:0] x_r [N+1];
  logic signed [W-1:0] y_r [N+1];
  logic signed [W-1:0] z_r [N+1];
  logic                neg_r [N+1];
  logic signed [OW-1:0] s_r, c_r;

  logic [31:0] phase;
  logic [1:0]  quad;
  assign phase = {angle, {(32-ANGLE_WIDTH){1'b0}}};
  assign quad  = phase[31:30];

  always_ff @(posedge clk) begin
    x_r[0]   <= afk_pkg::CordicStart;
    y_r[0]   <= '0;
    neg_r[0] <= (quad == 2'd1) || (quad == 2'd2);
    z_r[0]   <= W'($signed(((quad == 2'd1) || (quad == 2'd2)) ?
                            (phase ^ 32'h8000_0000) : phase));
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!z_r[i][W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - afk_pkg::arc_step(5'(i));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + afk_pkg::arc_step(5'(i));
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  function automatic logic signed [OW-1:0] rnd(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    logic signed [W-1:0] lim;
    t   = (v + (W'(1) <<< (RS-1))) >>> RS;
    lim = W'(1) <<< FRACTION_BITS;
    if (t > lim) t = lim;
    else if (t < -lim) t = -lim;
    rnd = OW'(t);
  endfunction

  logic signed [OW-1:0] xs, ys;
  assign xs = rnd(x_r[N]);
  assign ys = rnd(y_r[N]);

  always_ff @(posedge clk) begin
    s_r <= neg_r[N] ? -ys : ys;
    c_r <= neg_r[N] ? -xs : xs;
  end

  assign sin_q = s_r;
  assign cos_q = c_r;
endmodule

// ----- hw/rtl/afk_merge.sv -----
// afk_merge: combines the three lanes' sine/cosine into rotation and
// saturated position, three register stages. Does not reference afk_pkg.
`timescale 1ns / 1ps
module afk_merge #(
  parameter int FRACTION_BITS = 14,
  parameter int LENGTH_WIDTH  = 12
) (
  input  logic                            clk,
  input  logic [LENGTH_WIDTH-1:0]         l2,
  input  logic [LENGTH_WIDTH-1:0]         l3,
  input  logic signed [FRACTION_BITS+1:0] sb, cb, s2, c2, s23, c23,
  output logic signed [FRACTION_BITS+1:0] r11, r12, r13, r21, r22, r23, r31, r32,
  output logic signed [FRACTION_BITS+LENGTH_WIDTH+1:0] px, py, pz
);
  localparam int F  = FRACTION_BITS;
  localparam int RW = F + 2;
  localparam int PW = F + LENGTH_WIDTH + 2;
  localparam int AW = PW + 1;           // l*c sums
  localparam int MW = AW + RW;          // c*r products

  // stage 1: length products and rotation products
  logic signed [AW-1:0] r_r, z_r;
  logic signed [2*RW-1:0] p11_r, p12_r, p21_r, p22_r;
  logic signed [RW-1:0] sb1_r, cb1_r, s23_1_r, c23_1_r;

  always_ff @(posedge clk) begin
    r_r <= AW'($signed({1'b0, l2}) * c2) + AW'($signed({1'b0, l3}) * c23);
    z_r <= AW'($signed({1'b0, l2}) * s2) + AW'($signed({1'b0, l3}) * s23);
    p11_r <= cb * c23;
    p12_r <= cb * s23;
    p21_r <= sb * c23;
    p22_r <= sb * s23;
    sb1_r <= sb; cb1_r <= cb; s23_1_r <= s23; c23_1_r <= c23;
  end

  function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] v);
    rnd = (v + (MW'(1) <<< (F-1))) >>> F;
  endfunction

  function automatic logic signed [PW-1:0] sat(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] lim;
    lim = MW'(2 * ((1 << LENGTH_WIDTH) - 1)) <<< F;
    if (v > lim) sat = PW'(lim);
    else if (v < -lim) sat = PW'(-lim);
    else sat = PW'(v);
  endfunction

  // stage 2: position products
  logic signed [MW-1:0] mx_r, my_r, z2_r;
  logic signed [RW-1:0] q11_r, q12_r, q21_r, q22_r, q13_r, q23_r, q31_r, q32_r;

  always_ff @(posedge clk) begin
    mx_r  <= MW'(cb1_r * r_r);
    my_r  <= MW'(sb1_r * r_r);
    z2_r  <= MW'(z_r);
    q11_r <= RW'(rnd(MW'(p11_r)));
    q12_r <= RW'(-rnd(MW'(p12_r)));
    q21_r <= RW'(rnd(MW'(p21_r)));
    q22_r <= RW'(-rnd(MW'(p22_r)));
    q13_r <= sb1_r;
    q23_r <= -cb1_r;
    q31_r <= s23_1_r;
    q32_r <= c23_1_r;
  end

  // stage 3: round and saturate
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [RW-1:0] o11_r, o12_r, o13_r, o21_r, o22_r, o23_r, o31_r, o32_r;
  always_ff @(posedge clk) begin
    px_r <= sat(rnd(mx_r));
    py_r <= sat(rnd(my_r));
    pz_r <= sat(z2_r);
    o11_r <= q11_r; o12_r <= q12_r; o13_r <= q13_r;
    o21_r <= q21_r; o22_r <= q22_r; o23_r <= q23_r;
    o31_r <= q31_r; o32_r <= q32_r;
  end

  assign r11 = o11_r; assign r12 = o12_r; assign r13 = o13_r;
  assign r21 = o21_r; assign r22 = o22_r; assign r23 = o23_r;
  assign r31 = o31_r; assign r32 = o32_r;
  assign px = px_r; assign py = py_r; assign pz = pz_r;
endmodule

// ----- hw/rtl/arm_forward_kinematics_3dof_core.sv -----
// arm_forward_kinematics_3dof_core: top level of the 3-DOF forward kinematics
// engine. Depends on afk_pkg, afk_cordic_lane and afk_merge.
`timescale 1ns / 1ps
// Accepts one pose (three binary joint angles) on every clock where start is
// high; busy never rises, so a new pose can go in every cycle. Each pose
// yields one result beat, marked by out_valid, after 31 CORDIC lane stages
// plus output round, then three merge stages. Results cannot be stalled: the
// receiver must take out_valid beats as they come. Three CORDIC lanes (base,
// shoulder, shoulder+elbow) run side by side and a merge stage forms the
// rotation block and the saturated position. Link lengths are written through
// the cfg port; the user must do so only while no pose is in flight (not enforced).
module arm_forward_kinematics_3dof_core #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int FRACTION_BITS = 14,
  parameter int LENGTH_WIDTH  = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [ANGLE_WIDTH-1:0] in_base_joint_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_shoulder_joint_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_elbow_joint_angle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [LENGTH_WIDTH-1:0] cfg_data,
  output logic        out_valid,
  output logic signed [FRACTION_BITS+1:0] out_rot_row1_col1,
  output logic signed [FRACTION_BITS+1:0] out_rot_row1_col2,
  output logic signed [FRACTION_BITS+1:0] out_rot_row1_col3,
  output logic signed [FRACTION_BITS+1:0] out_rot_row2_col1,
  output logic signed [FRACTION_BITS+1:0] out_rot_row2_col2,
  output logic signed [FRACTION_BITS+1:0] out_rot_row2_col3,
  output logic signed [FRACTION_BITS+1:0] out_rot_row3_col1,
  output logic signed [FRACTION_BITS+1:0] out_rot_row3_col2,
  output logic        out_rot_row3_col3,
  output logic signed [FRACTION_BITS+LENGTH_WIDTH+1:0] out_pos_x,
  output logic signed [FRACTION_BITS+LENGTH_WIDTH+1:0] out_pos_y,
  output logic signed [FRACTION_BITS+LENGTH_WIDTH+1:0] out_pos_z
);
  localparam int RW = FRACTION_BITS + 2;
  localparam int Latency = afk_pkg::CordicSteps + 2 + 3;

  // Link length registers, reset to 3 units each.
  logic [LENGTH_WIDTH-1:0] l2_r, l3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_r <= LENGTH_WIDTH'(3);
      l3_r <= LENGTH_WIDTH'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (afk_pkg::cfg_idx_t'(cfg_index))
        afk_pkg::CFG_L2: l2_r <= cfg_data;
        afk_pkg::CFG_L3: l3_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  // Valid shift line tracking beats through the datapath.
  logic [Latency-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[Latency-2:0], start && !busy};
  end
  assign out_valid = vld_r[Latency-1];

  // Combined shoulder+elbow angle wraps modulo a turn.
  logic [ANGLE_WIDTH-1:0] a23;
  assign a23 = in_shoulder_joint_angle + in_elbow_joint_angle;

  logic signed [RW-1:0] sb, cb, s2, c2, s23, c23;

  afk_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane_b (
    .clk(clk), .angle(in_base_joint_angle), .sin_q(sb), .cos_q(cb));
  afk_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane_s (
    .clk(clk), .angle(in_shoulder_joint_angle), .sin_q(s2), .cos_q(c2));
  afk_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane_e (
    .clk(clk), .angle(a23), .sin_q(s23), .cos_q(c23));

  afk_merge #(.FRACTION_BITS(FRACTION_BITS), .LENGTH_WIDTH(LENGTH_WIDTH)) u_merge (
    .clk(clk), .l2(l2_r), .l3(l3_r),
    .sb(sb), .cb(cb), .s2(s2), .c2(c2), .s23(s23), .c23(c23),
    .r11(out_rot_row1_col1), .r12(out_rot_row1_col2), .r13(out_rot_row1_col3),
    .r21(out_rot_row2_col1), .r22(out_rot_row2_col2), .r23(out_rot_row2_col3),
    .r31(out_rot_row3_col1), .r32(out_rot_row3_col2),
    .px(out_pos_x), .py(out_pos_y), .pz(out_pos_z));

  assign out_rot_row3_col3 = 1'b0;

  // An accepted beat must surface on out_valid once it has passed the whole valid shift line.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(Latency-1) out_valid) else $error("result beat lost");
  // Nothing comes out after reset without an input.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("spurious result after reset");
endmodule

// ----- verif/tb_arm_forward_kinematics_3dof_core.sv -----
// tb_arm_forward_kinematics_3dof_core: self-checking testbench for the 3-DOF
// forward kinematics core; predicts each pose in a scoreboard class.
// Depends on afk_pkg and arm_forward_kinematics_3dof_core.
`timescale 1ns / 1ps

// One result beat: rotation block and position.
typedef struct {
  logic signed [15:0] rot [8];
  logic               r33;
  logic signed [27:0] px, py, pz;
} pose_t;

// Pose predictor and expected-result store.
class fk_scoreboard;
  pose_t  pending[$];
  longint link2 = 3, link3 = 3;
  int     mismatches = 0;
  int     strays = 0;

  static function longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  static function longint clampv(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  static function longint atan_step(int i);
    return longint'(afk_pkg::arc_step(5'(i)));
  endfunction

  // Rotation-mode CORDIC on a 32-bit turn phase, folded into quadrants 0 and 3.
  static function void sincos(logic [31:0] ph, output longint sn, output longint cs);
    bit     flip;
    longint x, y, z, t;
    flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
    if (flip) ph[31] = ~ph[31];
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - fshift(y, i); y = y + fshift(x, i); z = z - atan_step(i);
      end else begin
        t = x + fshift(y, i); y = y - fshift(x, i); z = z + atan_step(i);
      end
      x = t;
    end
    x = clampv(fshift(x + (1 << 15), 16), 1 << 14);
    y = clampv(fshift(y + (1 << 15), 16), 1 << 14);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  static function longint mulr(longint c, longint r);
    return fshift(c * r + (1 << 13), 14);
  endfunction

  function void set_length(bit idx, logic [11:0] v);
    if (idx == afk_pkg::CFG_L2) link2 = v; else link3 = v;
  endfunction

  function void note_pose(logic [15:0] b, logic [15:0] s, logic [15:0] e);
    longint sb, cb, s2, c2, s23, c23, r, z, lim;
    pose_t  p;
    lim = 2 * 4095 * (1 << 14);
    sincos({b, 16'h0}, sb, cb);
    sincos({s, 16'h0}, s2, c2);
    sincos({s, 16'h0} + {e, 16'h0}, s23, c23);
    r = link2 * c2 + link3 * c23;
    z = link2 * s2 + link3 * s23;
    p.rot[0] = 16'(mulr(cb, c23));  p.rot[1] = 16'(-mulr(cb, s23)); p.rot[2] = 16'(sb);
    p.rot[3] = 16'(mulr(sb, c23));  p.rot[4] = 16'(-mulr(sb, s23)); p.rot[5] = 16'(-cb);
    p.rot[6] = 16'(s23);            p.rot[7] = 16'(c23);
    p.r33 = 1'b0;
    p.px = 28'(clampv(mulr(cb, r), lim));
    p.py = 28'(clampv(mulr(sb, r), lim));
    p.pz = 28'(clampv(z, lim));
    pending.push_back(p);
  endfunction

  function void check_pose(pose_t got);
    pose_t exp_p;
    bit    ok;
    if (pending.size() == 0) begin
      strays++;
      if (mismatches + strays <= 10) $display("unexpected result beat at %0t", $time);
      return;
    end
    exp_p = pending.pop_front();
    ok = (got.r33 === exp_p.r33) && (got.px === exp_p.px) && (got.py === exp_p.py)
         && (got.pz === exp_p.pz);
    for (int i = 0; i < 8; i++) ok = ok && (got.rot[i] === exp_p.rot[i]);
    if (!ok) begin
      mismatches++;
      if (mismatches + strays <= 10) begin
        $display("mismatch at %0t", $time);
        for (int i = 0; i < 8; i++)
          $display("  rot[%0d] exp %0d got %0d", i, exp_p.rot[i], got.rot[i]);
        $display("  r33 exp %0d got %0d", exp_p.r33, got.r33);
        $display("  pos exp %0d %0d %0d got %0d %0d %0d", exp_p.px, exp_p.py, exp_p.pz,
                 got.px, got.py, got.pz);
      end
    end
  endfunction
endclass

module tb_arm_forward_kinematics_3dof_core;
  localparam int PipeDepth = 35;
  localparam int Watchdog  = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic signed [15:0] in_base_joint_angle = '0;
  logic signed [15:0] in_shoulder_joint_angle = '0;
  logic signed [15:0] in_elbow_joint_angle = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        out_valid;
  logic signed [15:0] out_rot_row1_col1, out_rot_row1_col2, out_rot_row1_col3;
  logic signed [15:0] out_rot_row2_col1, out_rot_row2_col2, out_rot_row2_col3;
  logic signed [15:0] out_rot_row3_col1, out_rot_row3_col2;
  logic        out_rot_row3_col3;
  logic signed [27:0] out_pos_x, out_pos_y, out_pos_z;

  fk_scoreboard poses = new();
  int idle_cycles = 0;
  int send_idle_pct = 0;   // chance of an empty cycle between poses

  // directed angles and per-phase settings
  logic [15:0] corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h7FFF, 16'h8001, 16'hFFFF, 16'h3FFF};
  int idle_mix[4] = '{0, 75, 0, 12};
  logic [11:0] lengths[5][2] = '{'{12'd3, 12'd3}, '{12'd4095, 12'd4095},
                                 '{12'd0, 12'd0}, '{12'd4095, 12'd0},
                                 '{12'd1, 12'd2048}};

  always #2 clk = ~clk;

  arm_forward_kinematics_3dof_core i_dut (.*);

  // Monitor: a beat moves on any edge where start meets !busy; results
  // are taken whenever out_valid is high since they cannot be held off.
  always @(posedge clk) begin
    pose_t got;
    if (rst_n) begin
      if (start && !busy)
        poses.note_pose(in_base_joint_angle, in_shoulder_joint_angle, in_elbow_joint_angle);
      if (cfg_valid && cfg_ready) poses.set_length(cfg_index, cfg_data);
      if (out_valid) begin
        got.rot[0] = out_rot_row1_col1; got.rot[1] = out_rot_row1_col2;
        got.rot[2] = out_rot_row1_col3; got.rot[3] = out_rot_row2_col1;
        got.rot[4] = out_rot_row2_col2; got.rot[5] = out_rot_row2_col3;
        got.rot[6] = out_rot_row3_col1; got.rot[7] = out_rot_row3_col2;
        got.r33 = out_rot_row3_col3;
        got.px = out_pos_x; got.py = out_pos_y; got.pz = out_pos_z;
        poses.check_pose(got);
      end
      // watchdog: cycles with no beat of any kind
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= Watchdog) begin
      $display("[arm_forward_kinematics_3dof_core] ERROR");
      $finish;
    end
  end

  // Present one pose; keeps start high across back-to-back beats.
  task automatic send_pose(logic [15:0] b, logic [15:0] s, logic [15:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_base_joint_angle <= b;
    in_shoulder_joint_angle <= s;
    in_elbow_joint_angle <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_length(afk_pkg::cfg_idx_t idx, logic [11:0] v);
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let the pipe empty before touching the length registers.
  task automatic drain();
    start <= 1'b0;
    while (poses.pending.size() != 0) @(negedge clk);
    repeat (PipeDepth + 5) @(negedge clk);
  endtask

  task automatic random_poses(int n);
    logic [15:0] b, s, e;
    for (int k = 0; k < n; k++) begin
      b = 16'($urandom); s = 16'($urandom); e = 16'($urandom);
      // some poses sit on quadrant boundaries to hit the fold logic
      if ($urandom_range(7) == 0) b = {2'($urandom), 14'h0};
      if ($urandom_range(7) == 0) s = {2'($urandom), 14'h0} + 16'($urandom_range(2) - 1);
      if ($urandom_range(7) == 0) e = 16'h0;
      send_pose(b, s, e);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset lengths, axis-aligned and wrap-around angles
    for (int k = 0; k < 8; k++) send_pose(corners[k], corners[(k + 3) % 8], corners[7 - k]);
    send_pose(16'h4000, 16'h4000, 16'h4000);   // shoulder+elbow wraps
    send_pose(16'h8000, 16'h8000, 16'h8000);
    drain();

    // full-reach lengths push position toward saturation
    write_length(afk_pkg::CFG_L2, 12'd4095);
    write_length(afk_pkg::CFG_L3, 12'd4095);
    for (int k = 0; k < 8; k++) send_pose(corners[k], corners[k], 16'h0000);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      write_length(afk_pkg::CFG_L2, ph < 5 ? lengths[ph][0] : 12'($urandom));
      write_length(afk_pkg::CFG_L3, ph < 5 ? lengths[ph][1] : 12'($urandom));
      send_idle_pct = idle_mix[ph % 4];
      random_poses(100);
      drain();
    end

    if (poses.mismatches == 0 && poses.strays == 0 && poses.pending.size() == 0)
      $display("[arm_forward_kinematics_3dof_core] OK");
    else
      $display("[arm_forward_kinematics_3dof_core] ERROR");
    $finish;
  end
endmodule
